// ----- hdl/dotp_pkg.sv -----
// Shared types and constants for the DHCP option TLV parser.
// Holds the option codes, register indexes, reset defaults and the result layout.
// No dependencies.
`default_nettype none

package dotp_pkg;

   // Parser phase within one option.
   typedef enum logic [1:0] {
      PH_CODE = 2'd0,
      PH_LEN  = 2'd1,
      PH_VAL  = 2'd2,
      PH_STOP = 2'd3
   } phase_type;

   // Option codes of interest.
   localparam logic [7:0] OPT_PAD       = 8'd0;
   localparam logic [7:0] OPT_SUBNET    = 8'd1;
   localparam logic [7:0] OPT_ROUTER    = 8'd3;
   localparam logic [7:0] OPT_DNS       = 8'd6;
   localparam logic [7:0] OPT_LEASE     = 8'd51;
   localparam logic [7:0] OPT_MSG_KIND  = 8'd53;
   localparam logic [7:0] OPT_SERVER_ID = 8'd54;
   localparam logic [7:0] OPT_RENEWAL   = 8'd58;
   localparam logic [7:0] OPT_REBINDING = 8'd59;
   localparam logic [7:0] OPT_END       = 8'd255;

   // Configuration register indexes.
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_SUBNET    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_LEASE     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_RENEWAL   = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DEFAULT_REBINDING = 2'd3;

   // Register reset values.
   localparam logic [31:0] RST_DEFAULT_SUBNET    = 32'hFFFF_FF00;
   localparam logic [31:0] RST_DEFAULT_LEASE     = 32'd86400;
   localparam logic [31:0] RST_DEFAULT_RENEWAL   = 32'd43200;
   localparam logic [31:0] RST_DEFAULT_REBINDING = 32'd75600;

   // Assembly counter saturates at four value bytes.
   localparam logic [2:0] VALUE_FULL = 3'd4;

   // Configured defaults.
   typedef struct packed {
      logic [31:0] subnet;
      logic [31:0] lease;
      logic [31:0] renewal;
      logic [31:0] rebinding;
   } defaults_type;

   // Result item; the last member sits in the lowest bits.
   typedef struct packed {
      logic [31:0] rebinding_secs;
      logic [31:0] renewal_secs;
      logic [31:0] lease_secs;
      logic [31:0] server_id;
      logic [31:0] dns_addr;
      logic [31:0] router_addr;
      logic [31:0] subnet_mask;
      logic [7:0]  message_kind;
   } result_type;

   localparam int unsigned RESULT_W = $bits(result_type);

endpackage

`default_nettype wire

// ----- hdl/dhcp_option_tlv_parser.sv -----
// DHCP option TLV parser: one options byte per transaction, one result per area.
// rsp_tvalid rises when the output register loads the result of the held final byte.
// Throughput: one byte per cycle; the input register stalls only while a result
// waits in the output register and the next final byte is ready behind it.
// Reset: synchronous, active high; clears parse state and restores default registers.
// Uses dotp_pkg, dotp_csr, dotp_parse and dotp_rsp_reg.
`default_nettype none

module dhcp_option_tlv_parser
   import dotp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   // Byte stream
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   input  wire logic [7:0]             req_tdata,   // [7:0] opt_byte
   input  wire logic                   req_tlast,   // last_byte
   // Result stream
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // [7:0] message_kind, [39:8] subnet_mask, [71:40] router_addr, [103:72] dns_addr,
   // [135:104] server_id, [167:136] lease_secs, [199:168] renewal_secs,
   // [231:200] rebinding_secs
   output logic [RESULT_W-1:0]         rsp_tdata,
   // Configuration writes
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]            csr_data
);

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic         in_last_ff;
   logic         advance;
   logic         rsp_free;
   defaults_type defaults;
   result_type   result;

   dotp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .defaults  (defaults)
   );

   // Input register: the held byte moves on unless it is final and the output is full.
   assign advance     = in_valid_ff && (!in_last_ff || rsp_free);
   assign req_tready  = !in_valid_ff || advance;
   assign in_valid_in = (req_tvalid && req_tready) || (in_valid_ff && !advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   dotp_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .opt_byte  (in_byte_ff),
      .last_byte (in_last_ff),
      .defaults  (defaults),
      .result    (result)
   );

   dotp_rsp_reg u_rsp (
      .clock      (clock),
      .reset      (reset),
      .load       (advance && in_last_ff),
      .data       (result),
      .free       (rsp_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

`ifndef SYNTHESIS
   // A result appears only after a final byte has been parsed.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_tvalid && !(advance && in_last_ff)) |=> !rsp_tvalid)
      else $error("result raised without a final byte");

   // The input stalls only behind a final byte blocked by a full output.
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (in_valid_ff && in_last_ff && rsp_tvalid && !rsp_tready))
      else $error("input stalled without cause");

   // A held byte that does not advance is kept.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("held byte lost");
`endif

endmodule

`default_nettype wire

// ----- hdl/dotp_csr.sv -----
// Configuration register bank for the DHCP option TLV parser.
// Holds the four default values; depends on dotp_pkg.
`default_nettype none

module dotp_csr
   import dotp_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]            csr_data,
   output defaults_type                defaults
);

   defaults_type defaults_ff;
   defaults_type defaults_in;

   // The bank accepts a write transaction in every cycle.
   assign csr_ready = 1'b1;

   // Decode the register index of a write.
   always_comb begin
      defaults_in = defaults_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DEFAULT_SUBNET:    defaults_in.subnet    = csr_data;
            CSR_DEFAULT_LEASE:     defaults_in.lease     = csr_data;
            CSR_DEFAULT_RENEWAL:   defaults_in.renewal   = csr_data;
            CSR_DEFAULT_REBINDING: defaults_in.rebinding = csr_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         defaults_ff.subnet    <= RST_DEFAULT_SUBNET;
         defaults_ff.lease     <= RST_DEFAULT_LEASE;
         defaults_ff.renewal   <= RST_DEFAULT_RENEWAL;
         defaults_ff.rebinding <= RST_DEFAULT_REBINDING;
      end else begin
         defaults_ff <= defaults_in;
      end
   end

   assign defaults = defaults_ff;

endmodule

`default_nettype wire

// ----- hdl/dotp_parse.sv -----
// Option parser state and its combinational update for one options byte.
// Produces the result for the final byte combinationally; depends on dotp_pkg.
`default_nettype none

module dotp_parse
   import dotp_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         step,
   input  wire logic [7:0]   opt_byte,
   input  wire logic         last_byte,
   input  wire defaults_type defaults,
   output result_type        result
);

   phase_type   phase_ff,  phase_in;
   logic [7:0]  code_ff,   code_in;
   logic [7:0]  left_ff,   left_in;
   logic [2:0]  count_ff,  count_in;
   logic [31:0] asm_ff,    asm_in;
   logic [7:0]  msg_ff,    msg_in;
   logic [31:0] subnet_ff, subnet_in;
   logic [31:0] router_ff, router_in;
   logic [31:0] dns_ff,    dns_in;
   logic [31:0] server_ff, server_in;
   logic [31:0] lease_ff,  lease_in;
   logic [31:0] renew_ff,  renew_in;
   logic [31:0] rebind_ff, rebind_in;
   // Seen flags: subnet, lease, renewal, rebinding.
   logic [3:0]  seen_ff,   seen_in;
   logic        commit;
   logic        four;
   logic [7:0]  first_byte;

   // Phase walk and value assembly for this byte.
   always_comb begin
      phase_in = phase_ff;
      code_in  = code_ff;
      left_in  = left_ff;
      count_in = count_ff;
      asm_in   = asm_ff;
      commit   = 1'b0;
      unique case (phase_ff)
         PH_CODE: begin
            if (opt_byte == OPT_END) begin
               phase_in = PH_STOP;
            end else if (opt_byte != OPT_PAD) begin
               code_in  = opt_byte;
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            // A zero-length option is complete here but sets nothing.
            left_in  = opt_byte;
            count_in = 3'd0;
            asm_in   = 32'd0;
            phase_in = (opt_byte == 8'd0) ? PH_CODE : PH_VAL;
         end
         PH_VAL: begin
            if (count_ff < VALUE_FULL) begin
               asm_in   = {asm_ff[23:0], opt_byte};
               count_in = count_ff + 3'd1;
            end
            left_in = left_ff - 8'd1;
            if (left_ff == 8'd1) begin
               commit   = 1'b1;
               phase_in = PH_CODE;
            end
         end
         PH_STOP: begin
         end
      endcase
   end

   // The first value byte sits above the bytes assembled after it.
   always_comb begin
      case (count_in)
         3'd1:    first_byte = asm_in[7:0];
         3'd2:    first_byte = asm_in[15:8];
         3'd3:    first_byte = asm_in[23:16];
         default: first_byte = asm_in[31:24];
      endcase
   end

   assign four = (count_in == VALUE_FULL);

   // Commit a completed option into the held values.
   always_comb begin
      msg_in    = msg_ff;
      subnet_in = subnet_ff;
      router_in = router_ff;
      dns_in    = dns_ff;
      server_in = server_ff;
      lease_in  = lease_ff;
      renew_in  = renew_ff;
      rebind_in = rebind_ff;
      seen_in   = seen_ff;
      if (commit) begin
         case (code_ff)
            OPT_MSG_KIND: begin
               if (count_in != 3'd0) msg_in = first_byte;
            end
            OPT_SUBNET: begin
               if (four) begin
                  subnet_in  = asm_in;
                  seen_in[0] = 1'b1;
               end
            end
            OPT_ROUTER: begin
               if (four) router_in = asm_in;
            end
            OPT_DNS: begin
               if (four) dns_in = asm_in;
            end
            OPT_SERVER_ID: begin
               if (four) server_in = asm_in;
            end
            OPT_LEASE: begin
               if (four) begin
                  lease_in   = asm_in;
                  seen_in[1] = 1'b1;
               end
            end
            OPT_RENEWAL: begin
               if (four) begin
                  renew_in   = asm_in;
                  seen_in[2] = 1'b1;
               end
            end
            OPT_REBINDING: begin
               if (four) begin
                  rebind_in  = asm_in;
                  seen_in[3] = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Final-byte result; unseen subnet, lease, renewal, rebinding take defaults.
   always_comb begin
      result.message_kind   = msg_in;
      result.subnet_mask    = seen_in[0] ? subnet_in : defaults.subnet;
      result.router_addr    = router_in;
      result.dns_addr       = dns_in;
      result.server_id      = server_in;
      result.lease_secs     = seen_in[1] ? lease_in  : defaults.lease;
      result.renewal_secs   = seen_in[2] ? renew_in  : defaults.renewal;
      result.rebinding_secs = seen_in[3] ? rebind_in : defaults.rebinding;
   end

   // State update; the final byte of an area starts the next one afresh.
   always_ff @(posedge clock) begin
      if (reset || (step && last_byte)) begin
         phase_ff  <= PH_CODE;
         code_ff   <= 8'd0;
         left_ff   <= 8'd0;
         count_ff  <= 3'd0;
         asm_ff    <= 32'd0;
         msg_ff    <= 8'd0;
         subnet_ff <= 32'd0;
         router_ff <= 32'd0;
         dns_ff    <= 32'd0;
         server_ff <= 32'd0;
         lease_ff  <= 32'd0;
         renew_ff  <= 32'd0;
         rebind_ff <= 32'd0;
         seen_ff   <= 4'd0;
      end else if (step) begin
         phase_ff  <= phase_in;
         code_ff   <= code_in;
         left_ff   <= left_in;
         count_ff  <= count_in;
         asm_ff    <= asm_in;
         msg_ff    <= msg_in;
         subnet_ff <= subnet_in;
         router_ff <= router_in;
         dns_ff    <= dns_in;
         server_ff <= server_in;
         lease_ff  <= lease_in;
         renew_ff  <= renew_in;
         rebind_ff <= rebind_in;
         seen_ff   <= seen_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/dotp_rsp_reg.sv -----
// Result output register for the DHCP option TLV parser.
// Holds one result transaction until the consumer takes it; depends on dotp_pkg.
`default_nettype none

module dotp_rsp_reg
   import dotp_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire result_type          data,
   output logic                     free,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [RESULT_W-1:0]      rsp_tdata
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   // Room for a new result when empty or when the held one leaves now.
   assign free     = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

`default_nettype wire

// ----- test/dhcp_option_tlv_parser_tb.sv -----
// Self-checking testbench for dhcp_option_tlv_parser: feeds options areas one byte
// per transaction, predicts each result in a scoreboard class and checks every field.
// Depends on dotp_pkg and the dhcp_option_tlv_parser RTL only.

module dhcp_option_tlv_parser_tb
   import dotp_pkg::*;
();

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned BYTE_TARGET = 1500;
   localparam int unsigned RANDOM_PASSES = 4;

   // Tracks the parser state and the lease details that each options area yields.
   class dhcp_lease_tracker;
      logic [31:0] dflt_subnet;
      logic [31:0] dflt_lease;
      logic [31:0] dflt_renewal;
      logic [31:0] dflt_rebinding;
      phase_type   stage;
      logic [7:0]  opt_code;
      logic [7:0]  remaining;
      logic [2:0]  fill;
      logic [31:0] gathered;
      logic [7:0]  held_type;
      logic [31:0] held_addr[4];    // subnet, router, dns, server id
      logic [31:0] held_time[3];    // lease, renewal, rebinding
      logic [3:0]  seen_mask;       // subnet, lease, renewal, rebinding
      result_type  pending_leases[$];
      int          errors;

      function new();
         dflt_subnet    = RST_DEFAULT_SUBNET;
         dflt_lease     = RST_DEFAULT_LEASE;
         dflt_renewal   = RST_DEFAULT_RENEWAL;
         dflt_rebinding = RST_DEFAULT_REBINDING;
         errors = 0;
         restart_area();
      endfunction

      function void restart_area();
         stage     = PH_CODE;
         opt_code  = '0;
         remaining = '0;
         fill      = '0;
         gathered  = '0;
         held_type = '0;
         foreach (held_addr[i]) held_addr[i] = '0;
         foreach (held_time[i]) held_time[i] = '0;
         seen_mask = '0;
      endfunction

      // A finished option updates the held values only if it carries enough bytes.
      function void commit_option();
         case (opt_code)
            OPT_MSG_KIND: if (fill != 0) held_type = 8'(gathered >> (8 * (fill - 1)));
            OPT_SUBNET: if (fill == VALUE_FULL) begin
               held_addr[0] = gathered;
               seen_mask[0] = 1'b1;
            end
            OPT_ROUTER:    if (fill == VALUE_FULL) held_addr[1] = gathered;
            OPT_DNS:       if (fill == VALUE_FULL) held_addr[2] = gathered;
            OPT_SERVER_ID: if (fill == VALUE_FULL) held_addr[3] = gathered;
            OPT_LEASE: if (fill == VALUE_FULL) begin
               held_time[0] = gathered;
               seen_mask[1] = 1'b1;
            end
            OPT_RENEWAL: if (fill == VALUE_FULL) begin
               held_time[1] = gathered;
               seen_mask[2] = 1'b1;
            end
            OPT_REBINDING: if (fill == VALUE_FULL) begin
               held_time[2] = gathered;
               seen_mask[3] = 1'b1;
            end
            default: ;
         endcase
      endfunction

      // Notes one accepted byte; the final byte of an area yields one expected result.
      function void take_byte(logic [7:0] b, logic last);
         result_type r;
         case (stage)
            PH_CODE: begin
               if (b == OPT_END) stage = PH_STOP;
               else if (b != OPT_PAD) begin
                  opt_code = b;
                  stage = PH_LEN;
               end
            end
            PH_LEN: begin
               remaining = b;
               fill = '0;
               gathered = '0;
               if (b == 8'd0) begin
                  commit_option();
                  stage = PH_CODE;
               end else begin
                  stage = PH_VAL;
               end
            end
            PH_VAL: begin
               if (fill < VALUE_FULL) begin
                  gathered = {gathered[23:0], b};
                  fill = fill + 3'd1;
               end
               remaining = remaining - 8'd1;
               if (remaining == 8'd0) begin
                  commit_option();
                  stage = PH_CODE;
               end
            end
            default: ;
         endcase
         if (last) begin
            r.message_kind   = held_type;
            r.subnet_mask    = seen_mask[0] ? held_addr[0] : dflt_subnet;
            r.router_addr    = held_addr[1];
            r.dns_addr       = held_addr[2];
            r.server_id      = held_addr[3];
            r.lease_secs     = seen_mask[1] ? held_time[0] : dflt_lease;
            r.renewal_secs   = seen_mask[2] ? held_time[1] : dflt_renewal;
            r.rebinding_secs = seen_mask[3] ? held_time[2] : dflt_rebinding;
            pending_leases.push_back(r);
            restart_area();
         end
      endfunction

      function void match_field(string field, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $error("%s: expected %h, got %h", field, want, got);
            errors++;
         end
      endfunction

      // Compares one accepted result with the oldest expected one.
      function void check_lease(result_type got);
         result_type want;
         if (pending_leases.size() == 0) begin
            $error("unexpected result: message_kind %h, server_id %h",
                   got.message_kind, got.server_id);
            errors++;
         end else begin
            want = pending_leases.pop_front();
            match_field("message_kind", 32'(want.message_kind), 32'(got.message_kind));
            match_field("subnet_mask", want.subnet_mask, got.subnet_mask);
            match_field("router_addr", want.router_addr, got.router_addr);
            match_field("dns_addr", want.dns_addr, got.dns_addr);
            match_field("server_id", want.server_id, got.server_id);
            match_field("lease_secs", want.lease_secs, got.lease_secs);
            match_field("renewal_secs", want.renewal_secs, got.renewal_secs);
            match_field("rebinding_secs", want.rebinding_secs, got.rebinding_secs);
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [7:0]             req_tdata;   // [7:0] opt_byte
   logic                   req_tlast;   // last_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // [7:0] message_kind, [39:8] subnet_mask, [71:40] router_addr, [103:72] dns_addr,
   // [135:104] server_id, [167:136] lease_secs, [199:168] renewal_secs,
   // [231:200] rebinding_secs
   logic [RESULT_W-1:0]    rsp_tdata;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [31:0]            csr_data;

   dhcp_lease_tracker tracker = new();
   logic              steady = 1'b0;
   int unsigned       bytes_sent = 0;
   int unsigned       cycles = 0;

   dhcp_option_tlv_parser dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Run guard: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Result side: check each completed transaction; stall at random unless steady.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) tracker.check_lease(result_type'(rsp_tdata));
         rsp_tready <= steady || ($urandom_range(99) >= 30);
      end
   end

   // Offers one byte, with an occasional gap in front of it, and waits for acceptance.
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!steady && $urandom_range(99) < 25) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 2)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      tracker.take_byte(b, last);
   endtask

   task automatic send_area(input logic [7:0] area[$]);
      foreach (area[i]) send_byte(area[i], i == area.size() - 1);
      bytes_sent += area.size();
   endtask

   // Holds the stream idle until every expected result has come back.
   task automatic drain();
      req_tvalid <= 1'b0;
      while (tracker.pending_leases.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
   endtask

   // Leaves csr_valid high so that consecutive writes follow without a gap.
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx, input logic [31:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_DEFAULT_SUBNET:    tracker.dflt_subnet = value;
         CSR_DEFAULT_LEASE:     tracker.dflt_lease = value;
         CSR_DEFAULT_RENEWAL:   tracker.dflt_renewal = value;
         CSR_DEFAULT_REBINDING: tracker.dflt_rebinding = value;
         default: ;
      endcase
   endtask

   task automatic write_defaults(input logic [31:0] subnet, input logic [31:0] lease,
                                 input logic [31:0] renewal, input logic [31:0] rebinding);
      write_reg(CSR_DEFAULT_SUBNET, subnet);
      write_reg(CSR_DEFAULT_LEASE, lease);
      write_reg(CSR_DEFAULT_RENEWAL, renewal);
      write_reg(CSR_DEFAULT_REBINDING, rebinding);
      csr_valid <= 1'b0;
   endtask

   // Builds one options area: mostly well-formed options with random content,
   // some with odd lengths, plus pad, end codes, unknown codes, noise and truncation.
   function automatic void build_area(ref logic [7:0] area[$]);
      int         shape;
      int         len;
      int         keep;
      logic [7:0] code;
      area.delete();
      if ($urandom_range(99) < 8) begin
         repeat ($urandom_range(1, 16)) area.push_back(8'($urandom));
      end else begin
         repeat ($urandom_range(0, 6)) begin
            shape = $urandom_range(99);
            if (shape < 6) begin
               area.push_back(OPT_PAD);
            end else if (shape < 10) begin
               area.push_back(OPT_END);
               repeat ($urandom_range(0, 3)) area.push_back(8'($urandom));
            end else begin
               case ($urandom_range(0, 8))
                  0: code = OPT_SUBNET;
                  1: code = OPT_ROUTER;
                  2: code = OPT_DNS;
                  3: code = OPT_SERVER_ID;
                  4: code = OPT_LEASE;
                  5: code = OPT_RENEWAL;
                  6: code = OPT_REBINDING;
                  7: code = OPT_MSG_KIND;
                  default: code = 8'($urandom_range(1, 254));
               endcase
               len = (code == OPT_MSG_KIND) ? 1 : 4;
               shape = $urandom_range(99);
               if (shape < 12) len = $urandom_range(0, 7);
               else if (shape < 15) len = $urandom_range(8, 24);
               else if (shape < 16) len = $urandom_range(25, 255);
               area.push_back(code);
               area.push_back(8'(len));
               repeat (len) area.push_back(8'($urandom));
            end
         end
      end
      if (area.size() == 0) area.push_back(8'($urandom));
      // Cut some areas short so that the final byte lands inside an option.
      if ($urandom_range(99) < 15) begin
         keep = $urandom_range(1, area.size());
         while (area.size() > keep) void'(area.pop_back());
      end
   endfunction

   initial begin
      logic [7:0]  area[$];
      int unsigned target;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tlast  <= 1'b0;
      csr_valid  <= 1'b0;
      csr_index  <= CSR_DEFAULT_SUBNET;
      csr_data   <= '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed areas under the reset defaults.
      // End code on the final byte itself.
      area = '{OPT_END};
      send_area(area);
      // Pad, two-byte message type, all-zero lease completing on the final byte.
      area = '{OPT_PAD, OPT_MSG_KIND, 8'd2, 8'hFF, 8'h01, OPT_LEASE, 8'd4,
               8'h00, 8'h00, 8'h00, 8'h00};
      send_area(area);
      // Zero-length, short, unknown and long options, then bytes after an end code.
      area = '{OPT_ROUTER, 8'd0, OPT_DNS, 8'd2, 8'h01, 8'h02, 8'd200, 8'd1, 8'h09,
               OPT_SERVER_ID, 8'd5, 8'h81, 8'h42, 8'h24, 8'h18, 8'h55, OPT_END,
               OPT_SUBNET};
      send_area(area);
      // Truncated inside the value, then just after the length byte.
      area = '{OPT_RENEWAL, 8'd4, 8'h01, 8'h02};
      send_area(area);
      area = '{OPT_REBINDING, 8'd4};
      send_area(area);
      drain();

      // Random areas under several default settings, extremes first.
      for (int pass = 0; pass < RANDOM_PASSES; pass++) begin
         case (pass)
            0: write_defaults('0, '0, '0, '0);
            1: write_defaults('1, '1, '1, '1);
            2: write_defaults($urandom, $urandom, $urandom, $urandom);
            default: write_defaults(RST_DEFAULT_SUBNET, RST_DEFAULT_LEASE,
                                    RST_DEFAULT_RENEWAL, RST_DEFAULT_REBINDING);
         endcase
         // One pass runs with neither side ever idling.
         steady = (pass == 2);
         target = bytes_sent + BYTE_TARGET / RANDOM_PASSES;
         while (bytes_sent < target) begin
            build_area(area);
            send_area(area);
         end
         drain();
      end

      if (tracker.errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- dhcp_option_tlv_parser.f -----
hdl/dotp_pkg.sv
hdl/dotp_csr.sv
hdl/dotp_parse.sv
hdl/dotp_rsp_reg.sv
hdl/dhcp_option_tlv_parser.sv
test/dhcp_option_tlv_parser_tb.sv
